FILE: design/fm_iq_modulator_unit_macros.svh
// Assertion macros used by the checker of the FM I/Q modulator.
`ifndef FM_IQ_MODULATOR_UNIT_MACROS_SVH
`define FM_IQ_MODULATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define FMIQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define FMIQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that stays active during reset.
`define FMIQ_ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/fmiq_pkg.sv
package fmiq_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int TABLE_ADDR_BITS = 10;

    localparam int DATA_W    = 16;
    localparam int GAIN_W    = 24;
    localparam int GAIN_FRAC = 8;
    localparam int AMP_W     = 15;

    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(109236);

    localparam int QUARTER    = 1 << (TABLE_ADDR_BITS - 2);
    localparam int IDX_W      = TABLE_ADDR_BITS - 1;
    localparam int ADDR_SHIFT = PHASE_BITS - TABLE_ADDR_BITS;

    localparam logic [63:0] HALFPI_Q30 = 64'd1686629713;
    localparam logic [63:0] AMPLITUDE  = 64'd32767;

    typedef struct packed {
        logic signed [DATA_W-1:0] deviation;
        logic                     restart;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] i_out;
        logic signed [DATA_W-1:0] q_out;
    } out_item_t;

    typedef logic [AMP_W-1:0] sine_table_t [QUARTER+1];

    // One quarter-wave entry, round(32767 * sin(k * pi / (2 * QUARTER))), from a
    // Taylor series in Q30 fixed point.
    function automatic logic [AMP_W-1:0] sine_entry(int k);
        logic [63:0]        x;
        logic [63:0]        term;
        logic [63:0]        v;
        logic signed [63:0] sum;
        int                 n;
        x    = (64'(k) * HALFPI_Q30 + 64'(QUARTER / 2)) >> (TABLE_ADDR_BITS - 2);
        term = x;
        sum  = $signed(x);
        for (n = 1; n <= 8; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            case (n)
                1:       term = term / 6;
                2:       term = term / 20;
                3:       term = term / 42;
                4:       term = term / 72;
                5:       term = term / 110;
                6:       term = term / 156;
                7:       term = term / 210;
                default: term = term / 272;
            endcase
            if ((n % 2) == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        v = ($unsigned(sum) * AMPLITUDE + 64'd536870912) >> 30;
        if (v > AMPLITUDE) begin
            v = AMPLITUDE;
        end
        return v[AMP_W-1:0];
    endfunction

    function automatic sine_table_t build_sine_table();
        sine_table_t t;
        int          k;
        for (k = 0; k <= QUARTER; k++) begin
            t[k] = sine_entry(k);
        end
        return t;
    endfunction

    localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage

FILE: design/fm_iq_modulator_unit.sv
// FM I/Q modulator: phase accumulator with quarter-wave sine and cosine lookup.
// An accepted request passes the deviation, step, phase and output registers to its I/Q result.
// Throughput: one request per cycle while m_ready does not stall the output; the accumulator loop holds only phase_reg.
// Reset (aresetn low, synchronous): pipeline emptied, phase cleared to zero,
// phase gain restored to 109236.
module fm_iq_modulator_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  fmiq_pkg::in_item_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output fmiq_pkg::out_item_t              m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fmiq_pkg::GAIN_W-1:0]      cfg_phase_gain
);

    localparam int PB     = fmiq_pkg::PHASE_BITS;
    localparam int PROD_W = fmiq_pkg::DATA_W + fmiq_pkg::GAIN_W + 1;
    localparam int EXT_W  = (PROD_W > PB) ? PROD_W : PB;
    localparam int TAB    = fmiq_pkg::TABLE_ADDR_BITS;
    localparam int IDX_W  = fmiq_pkg::IDX_W;

    localparam logic [PB-1:0] ROUND_HALF = PB'(1) << (fmiq_pkg::ADDR_SHIFT - 1);
    localparam logic [IDX_W-1:0] QUARTER_IDX = IDX_W'(fmiq_pkg::QUARTER);

    logic [fmiq_pkg::GAIN_W-1:0] gain_reg;

    logic                                v1_reg;
    logic signed [fmiq_pkg::DATA_W-1:0]  dev1_reg;
    logic                                rst1_reg;

    logic                                v2_reg;
    logic [PB-1:0]                       step2_reg;
    logic                                rst2_reg;

    logic                                v3_reg;
    logic [PB-1:0]                       phase_reg;

    logic                                m_valid_reg;
    fmiq_pkg::out_item_t                 m_data_reg;

    logic en1, en2, en3, en4;

    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] prod_shr;
    logic signed [EXT_W-1:0]  step_ext;
    logic [PB-1:0]            phase_next;

    logic [PB-1:0]            phase_rnd;
    logic [TAB-1:0]           addr;
    logic [1:0]               quad;
    logic [IDX_W-1:0]         k_idx;
    logic [IDX_W-1:0]         kc_idx;
    logic [fmiq_pkg::AMP_W-1:0] amp_k;
    logic [fmiq_pkg::AMP_W-1:0] amp_kc;
    logic signed [fmiq_pkg::DATA_W-1:0] pos_k, pos_kc;
    fmiq_pkg::out_item_t      out_next;

    assign en4 = !m_valid_reg || m_ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign s_ready   = en1;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Signed step: floor(deviation * gain / 256), wrapped to the phase width.
    assign prod     = PROD_W'(dev1_reg) * PROD_W'($signed({1'b0, gain_reg}));
    assign prod_shr = prod >>> fmiq_pkg::GAIN_FRAC;
    assign step_ext = EXT_W'(prod_shr);

    assign phase_next = (rst2_reg ? '0 : phase_reg) + step2_reg;

    assign phase_rnd = phase_reg + ROUND_HALF;
    assign addr      = phase_rnd[PB-1:fmiq_pkg::ADDR_SHIFT];
    assign quad      = addr[TAB-1:TAB-2];
    assign k_idx     = {1'b0, addr[TAB-3:0]};
    assign kc_idx    = QUARTER_IDX - k_idx;
    assign amp_k     = fmiq_pkg::SINE_TABLE[k_idx];
    assign amp_kc    = fmiq_pkg::SINE_TABLE[kc_idx];
    assign pos_k     = $signed({1'b0, amp_k});
    assign pos_kc    = $signed({1'b0, amp_kc});

    always_comb begin
        case (quad)
            2'd0: begin
                out_next.q_out = pos_k;
                out_next.i_out = pos_kc;
            end
            2'd1: begin
                out_next.q_out = pos_kc;
                out_next.i_out = -pos_k;
            end
            2'd2: begin
                out_next.q_out = -pos_k;
                out_next.i_out = -pos_kc;
            end
            default: begin
                out_next.q_out = -pos_kc;
                out_next.i_out = pos_k;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg    <= fmiq_pkg::GAIN_RESET;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            phase_reg   <= '0;
        end else begin
            if (cfg_valid) begin
                gain_reg <= cfg_phase_gain;
            end
            if (en1) begin
                v1_reg <= s_valid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en3) begin
                v3_reg <= v2_reg;
                if (v2_reg) begin
                    phase_reg <= phase_next;
                end
            end
            if (en4) begin
                m_valid_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1 && s_valid) begin
            dev1_reg <= s_data.deviation;
            rst1_reg <= s_data.restart;
        end
        if (en2 && v1_reg) begin
            step2_reg <= step_ext[PB-1:0];
            rst2_reg  <= rst1_reg;
        end
        if (en4 && v3_reg) begin
            m_data_reg <= out_next;
        end
    end

endmodule

FILE: design/fmiq_checker.sv
`include "fm_iq_modulator_unit_macros.svh"

module fmiq_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input fmiq_pkg::out_item_t         m_data
);

    logic out_stall;
    logic amp_ok;

    assign out_stall = m_valid && !m_ready;
    assign amp_ok    = (m_data.i_out != 16'sh8000) && (m_data.q_out != 16'sh8000);

    `FMIQ_ASSERT_NEXT(a_out_valid_holds, out_stall, m_valid, "result dropped while stalled")
    `FMIQ_ASSERT_NEXT(a_out_data_holds, out_stall, $stable(m_data), "result changed while stalled")
    `FMIQ_ASSERT_RST(a_reset_empties, !aresetn, !m_valid, "result shown right after reset")
    `FMIQ_ASSERT_NOW(a_amp_range, m_valid, amp_ok, "sample beyond amplitude")
    `FMIQ_ASSERT_NOW(a_stall_when_full, !s_ready, out_stall, "stall without backpressure")

endmodule

bind fm_iq_modulator_unit fmiq_checker u_fmiq_checker (.*);

FILE: tb/fm_iq_modulator_unit_test.sv
module fm_iq_modulator_unit_test;

    import fmiq_pkg::*;

    typedef enum logic [1:0] {
        QUAD_FIRST,
        QUAD_SECOND,
        QUAD_THIRD,
        QUAD_FOURTH
    } quadrant_t;

    class iq_scoreboard;
        logic [GAIN_W-1:0]     gain;
        logic [PHASE_BITS-1:0] phase;
        int                    quarter_wave [QUARTER+1];
        out_item_t             iq_due [$];
        int                    errors;
        int                    results_seen;

        function new();
            gain         = GAIN_RESET;
            phase        = '0;
            errors       = 0;
            results_seen = 0;
            for (int k = 0; k <= QUARTER; k++) begin
                quarter_wave[k] = sine_point(k);
            end
        endfunction

        // Q30 Taylor series of sin(k * pi / (2 * QUARTER)), scaled and rounded.
        function int sine_point(int k);
            longint unsigned x;
            longint unsigned t;
            longint unsigned v;
            longint          acc;
            x   = (64'(k) * HALFPI_Q30 + 64'(QUARTER / 2)) / 64'(QUARTER);
            t   = x;
            acc = longint'(x);
            for (int n = 1; n <= 8; n++) begin
                t = (t * x) >> 30;
                t = (t * x) >> 30;
                t = t / 64'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1) begin
                    acc = acc - longint'(t);
                end else begin
                    acc = acc + longint'(t);
                end
            end
            if (acc < 0) begin
                acc = 0;
            end
            v = (64'(acc) * AMPLITUDE + 64'd536870912) >> 30;
            if (v > AMPLITUDE) begin
                v = AMPLITUDE;
            end
            return int'(v);
        endfunction

        function int pending();
            return iq_due.size();
        endfunction

        function void note_request(in_item_t req);
            longint                     prod;
            logic [PHASE_BITS-1:0]      rounded;
            logic [TABLE_ADDR_BITS-1:0] addr;
            quadrant_t                  quad;
            int                         k;
            int                         sin_v;
            int                         cos_v;
            out_item_t                  iq;
            if (req.restart) begin
                phase = '0;
            end
            prod    = longint'(req.deviation) * longint'(gain);
            prod    = prod >>> GAIN_FRAC;
            phase   = phase + prod[PHASE_BITS-1:0];
            rounded = phase + (PHASE_BITS'(1) << (PHASE_BITS - TABLE_ADDR_BITS - 1));
            addr    = rounded[PHASE_BITS-1 -: TABLE_ADDR_BITS];
            quad    = quadrant_t'(addr[TABLE_ADDR_BITS-1 -: 2]);
            k       = int'(addr[TABLE_ADDR_BITS-3:0]);
            case (quad)
                QUAD_FIRST: begin
                    sin_v = quarter_wave[k];
                    cos_v = quarter_wave[QUARTER - k];
                end
                QUAD_SECOND: begin
                    sin_v = quarter_wave[QUARTER - k];
                    cos_v = -quarter_wave[k];
                end
                QUAD_THIRD: begin
                    sin_v = -quarter_wave[k];
                    cos_v = -quarter_wave[QUARTER - k];
                end
                default: begin
                    sin_v = -quarter_wave[QUARTER - k];
                    cos_v = quarter_wave[k];
                end
            endcase
            iq.i_out = DATA_W'(cos_v);
            iq.q_out = DATA_W'(sin_v);
            iq_due.push_back(iq);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            results_seen++;
            if (iq_due.size() == 0) begin
                $error("unexpected result: i_out %0d, q_out %0d", got.i_out, got.q_out);
                errors++;
                return;
            end
            want = iq_due.pop_front();
            if (got.i_out !== want.i_out) begin
                $error("i_out: expected %0d, actual %0d", want.i_out, got.i_out);
                errors++;
            end
            if (got.q_out !== want.q_out) begin
                $error("q_out: expected %0d, actual %0d", want.q_out, got.q_out);
                errors++;
            end
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    in_item_t          s_data;
    logic              m_valid;
    logic              m_ready;
    out_item_t         m_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [GAIN_W-1:0] cfg_phase_gain;

    iq_scoreboard board;
    logic         steady_send = 1'b0;
    logic         held_off = 1'b0;

    fm_iq_modulator_unit uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_phase_gain (cfg_phase_gain)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic send_request(logic signed [DATA_W-1:0] dev, logic restart);
        in_item_t req;
        int       gap;
        req.deviation = dev;
        req.restart   = restart;
        gap = steady_send ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        board.note_request(req);
    endtask

    task automatic write_gain(logic [GAIN_W-1:0] g);
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_phase_gain <= g;
        cfg_valid      <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        board.gain = g;
    endtask

    task automatic send_random(int count);
        logic signed [DATA_W-1:0] dev;
        int                       r;
        steady_send = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 9);
            if (r == 0) begin
                dev = 16'sh8000;
            end else if (r == 1) begin
                dev = 16'sh7FFF;
            end else if (r == 2) begin
                dev = DATA_W'($urandom_range(0, 15)) - 16'sd8;
            end else begin
                dev = DATA_W'($urandom);
            end
            send_request(dev, $urandom_range(0, 15) == 0);
        end
        steady_send = 1'b0;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_result(m_data);
        end
    end

    initial begin
        int run;
        int stall;
        m_ready = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            m_ready <= 1'b1;
            run = $urandom_range(1, 24);
            repeat (run) @(posedge aclk);
            if (!held_off && board.results_seen >= 150) begin
                held_off = 1'b1;
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
            end else begin
                stall = pick_gap();
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
        end
    end

    initial begin
        #5000000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        cfg_valid      = 1'b0;
        cfg_phase_gain = '0;
        board          = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_request(16'sd0, 1'b1);
        send_request(16'sh7FFF, 1'b0);
        send_request(16'sh8000, 1'b0);
        send_request(16'sd1, 1'b0);
        send_request(-16'sd1, 1'b0);
        send_request(16'sh8000, 1'b1);
        send_request(16'sh7FFF, 1'b1);

        // With this gain a deviation of 16384 is exactly an eighth of a turn.
        write_gain(24'h800000);
        send_request(16'sd16384, 1'b1);
        send_request(16'sd16384, 1'b0);
        send_request(16'sd16384, 1'b0);
        send_request(16'sd16384, 1'b0);
        send_request(16'sd64, 1'b1);
        send_request(16'sd63, 1'b1);
        send_request(-16'sd64, 1'b1);
        send_request(-16'sd65, 1'b1);
        send_request(16'sd8192, 1'b1);

        write_gain(24'hFFFFFF);
        send_request(16'sh7FFF, 1'b1);
        send_request(16'sh7FFF, 1'b0);
        send_request(16'sh8000, 1'b0);
        send_request(16'sh8000, 1'b0);
        send_request(16'sh8000, 1'b1);

        write_gain(24'h000000);
        send_request(16'sd12345, 1'b0);
        send_request(16'sh8000, 1'b1);
        send_request(16'sh7FFF, 1'b0);

        write_gain(GAIN_W'($urandom));
        send_random(200);
        write_gain(GAIN_RESET);
        send_random(200);
        write_gain(GAIN_W'($urandom_range(0, 24'h03FFFF)));
        send_random(200);
        write_gain(24'hFFFFFF);
        send_random(200);
        write_gain(GAIN_W'($urandom));
        send_random(200);

        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
